[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/atei_pkg.sv]
// ----------------------------------------------------------------------------
// atei_pkg
// Item types, outcome codes and sequencer states for the edge insert block.
// ----------------------------------------------------------------------------
package atei_pkg;

  typedef struct packed {
    logic [15:0] source_vertex;
    logic [15:0] dest_vertex;
    logic [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [5:0]  vertex_slot;
    logic [3:0]  neighbor_slot;
    logic [15:0] stored_weight;
  } out_item_t;

  localparam logic [2:0] OC_NEW_VERTEX   = 3'd0;
  localparam logic [2:0] OC_NEW_NEIGHBOR = 3'd1;
  localparam logic [2:0] OC_LOWERED      = 3'd2;
  localparam logic [2:0] OC_KEPT         = 3'd3;
  localparam logic [2:0] OC_VERTEX_FULL  = 3'd4;
  localparam logic [2:0] OC_LIST_FULL    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,
    ST_BASE,
    ST_CNT,
    ST_NSCAN,
    ST_NEWV,
    ST_OUT
  } state_t;

endpackage

[rtl/adjacency_table_edge_insert.sv]
// ----------------------------------------------------------------------------
// adjacency_table_edge_insert
// Weighted adjacency table, one directed edge inserted per item.
// ----------------------------------------------------------------------------
// One item at a time. The vertex label memory is scanned in slot order, one
// read per cycle, then the source's neighbor list in the same way; the one
// read port on each memory sets the pace. in_stall is high from acceptance
// until the result is loaded into the output register; the next item can be
// taken while that result still waits. The vertex count acts as fill count
// for all tables, so there is no clearing pass after reset.
module adjacency_table_edge_insert import atei_pkg::*; #(
  parameter int MAX_VERTICES  = 64,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int NCW = $clog2(MAX_NEIGHBORS + 1);
  localparam int ND  = MAX_VERTICES * MAX_NEIGHBORS;
  localparam int AW  = $clog2(ND);

  state_t         state_r, state_nxt;
  in_item_t       in_r, in_nxt;
  logic [VCW-1:0] vc_r, vc_nxt;
  logic [VCW-1:0] vi_r, vi_nxt;
  logic           vpend_r, vpend_nxt;
  logic [VW-1:0]  vcs_r, vcs_nxt;
  logic [VW-1:0]  vslot_r, vslot_nxt;
  logic           newv_r, newv_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [NCW-1:0] nc_r, nc_nxt;
  logic [NCW-1:0] ni_r, ni_nxt;
  logic           npend_r, npend_nxt;
  logic [NCW-1:0] ncs_r, ncs_nxt;
  out_item_t      res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  logic           vlab_we;
  logic [15:0]    vlab_rd;
  logic           ncnt_we;
  logic [NCW-1:0] ncnt_wd;
  logic [NCW-1:0] ncnt_rd;
  logic           nbr_we;
  logic [AW-1:0]  nbr_waddr;
  logic [AW-1:0]  nbr_raddr;
  logic [31:0]    nbr_rd;
  logic           vhit;
  logic           nhit;

  function automatic out_item_t mk_res(input logic [2:0] oc, input logic [VW-1:0] vs,
                                       input logic [NCW-1:0] ns, input logic [15:0] w);
    logic [VW+5:0]  vs_ext;
    logic [NCW+3:0] ns_ext;
    out_item_t      r;
    vs_ext = (VW + 6)'(vs);
    ns_ext = (NCW + 4)'(ns);
    r.outcome       = oc;
    r.vertex_slot   = vs_ext[5:0];
    r.neighbor_slot = ns_ext[3:0];
    r.stored_weight = w;
    return r;
  endfunction

  atei_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_vlab (
    .clk   (clk),
    .we    (vlab_we),
    .waddr (vslot_r),
    .wdata (in_r.source_vertex),
    .raddr (vi_r[VW-1:0]),
    .rdata (vlab_rd)
  );

  atei_ram #(.WIDTH(NCW), .DEPTH(MAX_VERTICES)) u_ncnt (
    .clk   (clk),
    .we    (ncnt_we),
    .waddr (vslot_r),
    .wdata (ncnt_wd),
    .raddr (vslot_r),
    .rdata (ncnt_rd)
  );

  // neighbor entry: label in the upper half, weight in the lower half
  atei_ram #(.WIDTH(32), .DEPTH(ND)) u_nbr (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata ({in_r.dest_vertex, in_r.edge_weight}),
    .raddr (nbr_raddr),
    .rdata (nbr_rd)
  );

  assign nbr_raddr = base_r + AW'(ni_r);
  assign vhit      = vpend_r && (vlab_rd == in_r.source_vertex);
  assign nhit      = npend_r && (nbr_rd[31:16] == in_r.dest_vertex);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    vi_r       <= vi_nxt;
    vpend_r    <= vpend_nxt;
    vcs_r      <= vcs_nxt;
    vslot_r    <= vslot_nxt;
    newv_r     <= newv_nxt;
    base_r     <= base_nxt;
    nc_r       <= nc_nxt;
    ni_r       <= ni_nxt;
    npend_r    <= npend_nxt;
    ncs_r      <= ncs_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    vc_nxt        = vc_r;
    vi_nxt        = vi_r;
    vpend_nxt     = vpend_r;
    vcs_nxt       = vcs_r;
    vslot_nxt     = vslot_r;
    newv_nxt      = newv_r;
    base_nxt      = base_r;
    nc_nxt        = nc_r;
    ni_nxt        = ni_r;
    npend_nxt     = npend_r;
    ncs_nxt       = ncs_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    vlab_we       = 1'b0;
    ncnt_we       = 1'b0;
    ncnt_wd       = NCW'(1);
    nbr_we        = 1'b0;
    nbr_waddr     = base_r;
    in_stall      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          in_nxt    = in_data;
          vi_nxt    = '0;
          vpend_nxt = 1'b0;
          state_nxt = ST_VSCAN;
        end
      end

      // read slot vi_r while comparing the data of slot vcs_r
      ST_VSCAN: begin
        if (vhit) begin
          vslot_nxt = vcs_r;
          newv_nxt  = 1'b0;
          state_nxt = ST_BASE;
        end else if (vi_r == vc_r) begin
          if (vc_r == VCW'(MAX_VERTICES)) begin
            res_nxt   = mk_res(OC_VERTEX_FULL, '0, '0, '0);
            state_nxt = ST_OUT;
          end else begin
            vslot_nxt = vc_r[VW-1:0];
            newv_nxt  = 1'b1;
            state_nxt = ST_BASE;
          end
        end else begin
          vcs_nxt   = vi_r[VW-1:0];
          vi_nxt    = vi_r + 1'b1;
          vpend_nxt = 1'b1;
        end
      end

      // neighbor count read for vslot_r is in flight here
      ST_BASE: begin
        base_nxt  = AW'(vslot_r * MAX_NEIGHBORS);
        ni_nxt    = '0;
        npend_nxt = 1'b0;
        state_nxt = newv_r ? ST_NEWV : ST_CNT;
      end

      ST_CNT: begin
        nc_nxt    = ncnt_rd;
        state_nxt = ST_NSCAN;
      end

      ST_NSCAN: begin
        if (nhit) begin
          if (nbr_rd[15:0] > in_r.edge_weight) begin
            nbr_we    = 1'b1;
            nbr_waddr = base_r + AW'(ncs_r);
            res_nxt   = mk_res(OC_LOWERED, vslot_r, ncs_r, in_r.edge_weight);
          end else begin
            res_nxt   = mk_res(OC_KEPT, vslot_r, ncs_r, nbr_rd[15:0]);
          end
          state_nxt = ST_OUT;
        end else if (ni_r == nc_r) begin
          if (nc_r == NCW'(MAX_NEIGHBORS)) begin
            res_nxt = mk_res(OC_LIST_FULL, vslot_r, '0, '0);
          end else begin
            nbr_we    = 1'b1;
            nbr_waddr = base_r + AW'(nc_r);
            ncnt_we   = 1'b1;
            ncnt_wd   = nc_r + 1'b1;
            res_nxt   = mk_res(OC_NEW_NEIGHBOR, vslot_r, nc_r, in_r.edge_weight);
          end
          state_nxt = ST_OUT;
        end else begin
          ncs_nxt   = ni_r;
          ni_nxt    = ni_r + 1'b1;
          npend_nxt = 1'b1;
        end
      end

      ST_NEWV: begin
        vlab_we   = 1'b1;
        ncnt_we   = 1'b1;
        nbr_we    = 1'b1;
        vc_nxt    = vc_r + 1'b1;
        res_nxt   = mk_res(OC_NEW_VERTEX, vslot_r, '0, in_r.edge_weight);
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/atei_ram.sv]
// ----------------------------------------------------------------------------
// atei_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module atei_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/atei_checker.sv]
// ----------------------------------------------------------------------------
// atei_checker
// Port-level checks for the edge insert block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atei_checker import atei_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_acc;
  logic out_hold;
  logic vfull_res;
  logic lfull_res;
  logic tail_zero;
  logic all_zero;

  assign in_acc    = in_valid && !in_stall;
  assign out_hold  = out_valid && out_stall;
  assign vfull_res = out_valid && (out_data.outcome == OC_VERTEX_FULL);
  assign lfull_res = out_valid && (out_data.outcome == OC_LIST_FULL);
  assign tail_zero = (out_data.neighbor_slot == '0) && (out_data.stored_weight == '0);
  assign all_zero  = tail_zero && (out_data.vertex_slot == '0);

  `ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "second item taken while busy")
  `ASSERT_IMPL(a_outcome_range, out_valid, out_data.outcome <= OC_LIST_FULL, "bad outcome code")
  `ASSERT_IMPL(a_vfull_zero, vfull_res, all_zero, "table full result not zero")
  `ASSERT_IMPL(a_lfull_zero, lfull_res, tail_zero, "list full result not zero")

endmodule

bind adjacency_table_edge_insert atei_checker u_atei_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the edge insert block against its own adjacency table predictor.
// A directed list covers field extremes, every outcome but table full, and a full list.
// Random edges then fill the table and drive lookups, lowering and keeping.
// Both sides idle at random, and one long output hold backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import atei_pkg::*;

  localparam int NUM_VERTICES  = 64;
  localparam int NUM_NEIGHBORS = 16;
  localparam int RANDOM_EDGES  = 1950;
  localparam int SRC_POOL_SIZE = 72;
  localparam int DST_POOL_SIZE = 24;
  localparam int DRAIN_CYCLES  = 120;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  adjacency_table_edge_insert i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted adjacency table contents
  logic [15:0] vtx_label   [NUM_VERTICES];
  int unsigned vtx_count;
  logic [15:0] nbr_label   [NUM_VERTICES][NUM_NEIGHBORS];
  logic [15:0] nbr_weight  [NUM_VERTICES][NUM_NEIGHBORS];
  int unsigned nbr_count   [NUM_VERTICES];

  in_item_t    pending_edges[$];
  out_item_t   expected_results[$];
  int          accepted_count = 0;
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  function automatic out_item_t predict_insert(in_item_t e);
    out_item_t r;
    int unsigned v;
    int unsigned n;
    int unsigned cnt;
    r = '0;
    v = 0;
    while (v < vtx_count && vtx_label[v] != e.source_vertex) v++;
    if (v == vtx_count) begin
      if (vtx_count >= NUM_VERTICES) begin
        r.outcome = OC_VERTEX_FULL;
        return r;
      end
      vtx_label[v]     = e.source_vertex;
      nbr_label[v][0]  = e.dest_vertex;
      nbr_weight[v][0] = e.edge_weight;
      nbr_count[v]     = 1;
      vtx_count++;
      r.outcome       = OC_NEW_VERTEX;
      r.vertex_slot   = v[5:0];
      r.stored_weight = e.edge_weight;
      return r;
    end
    r.vertex_slot = v[5:0];
    cnt = nbr_count[v];
    n = 0;
    while (n < cnt && nbr_label[v][n] != e.dest_vertex) n++;
    if (n == cnt) begin
      if (cnt >= NUM_NEIGHBORS) begin
        r.outcome = OC_LIST_FULL;
        return r;
      end
      nbr_label[v][n]  = e.dest_vertex;
      nbr_weight[v][n] = e.edge_weight;
      nbr_count[v]     = cnt + 1;
      r.outcome        = OC_NEW_NEIGHBOR;
      r.neighbor_slot  = n[3:0];
      r.stored_weight  = e.edge_weight;
      return r;
    end
    r.neighbor_slot = n[3:0];
    if (nbr_weight[v][n] > e.edge_weight) begin
      nbr_weight[v][n] = e.edge_weight;
      r.outcome = OC_LOWERED;
    end else begin
      r.outcome = OC_KEPT;
    end
    r.stored_weight = nbr_weight[v][n];
    return r;
  endfunction

  // Every fourth stretch of 128 items runs with no idling on either side
  function automatic bit quiet_phase();
    return ((accepted_count / 128) % 4) == 3;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase() || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 100)
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_edge(logic [15:0] src, logic [15:0] dst, logic [15:0] w);
    in_item_t e;
    e.source_vertex = src;
    e.dest_vertex   = dst;
    e.edge_weight   = w;
    pending_edges.push_back(e);
  endtask

  // Driver: offers the next pending item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_insert(in_data));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_edges.size() > 0) begin
          in_data  <= pending_edges.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold to fill the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall      <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && accepted_count >= 400) begin
      long_hold_done <= 1'b1;
      hold_left      <= 500;
      out_stall      <= 1'b1;
    end else if (!quiet_phase() && $urandom_range(0, 9) < 2) begin
      hold_left <= pick_idle();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, outcome", out_data.outcome, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.outcome != want.outcome)
          report_mismatch("outcome", out_data.outcome, want.outcome);
        if (out_data.vertex_slot != want.vertex_slot)
          report_mismatch("vertex_slot", out_data.vertex_slot, want.vertex_slot);
        if (out_data.neighbor_slot != want.neighbor_slot)
          report_mismatch("neighbor_slot", out_data.neighbor_slot, want.neighbor_slot);
        if (out_data.stored_weight != want.stored_weight)
          report_mismatch("stored_weight", out_data.stored_weight, want.stored_weight);
      end
    end
  end

  initial begin
    logic [15:0] src_pool [SRC_POOL_SIZE];
    logic [15:0] dst_pool [DST_POOL_SIZE];
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] w;
    int          lim;

    // Directed: extremes, every outcome but table full, one list filled past its end
    queue_edge(16'h0000, 16'h0000, 16'h0000);
    queue_edge(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_edge(16'h0000, 16'hFFFF, 16'hFFFF);
    queue_edge(16'h0000, 16'hFFFF, 16'h8000);
    queue_edge(16'h0000, 16'hFFFF, 16'h8000);
    queue_edge(16'h0000, 16'hFFFF, 16'hFFFF);
    queue_edge(16'hFFFF, 16'h0000, 16'h0000);
    queue_edge(16'hFFFF, 16'h0000, 16'h0001);
    for (int i = 1; i <= 14; i++) queue_edge(16'h0000, 16'(i), 16'h5555);
    queue_edge(16'h0000, 16'h8000, 16'h0001);
    queue_edge(16'h0000, 16'h0000, 16'h0000);
    queue_edge(16'h0000, 16'hFFFF, 16'h0000);

    // Random: sources drawn from a growing pool larger than the table, so the
    // table fills and later labels hit the full case; few destinations per
    // source so lists fill and repeat edges lower or keep weights
    foreach (src_pool[i]) src_pool[i] = $urandom;
    foreach (dst_pool[i]) dst_pool[i] = $urandom;
    for (int k = 0; k < RANDOM_EDGES; k++) begin
      lim = 4 + k / 20;
      if (lim > SRC_POOL_SIZE - 1) lim = SRC_POOL_SIZE - 1;
      if ($urandom_range(0, 99) < 3) src = $urandom;
      else src = src_pool[$urandom_range(0, lim)];
      if ($urandom_range(0, 9) == 0) dst = $urandom;
      else dst = dst_pool[$urandom_range(0, DST_POOL_SIZE - 1)];
      if ($urandom_range(0, 1) == 0) w = $urandom;
      else w = $urandom_range(0, 63);
      queue_edge(src, dst, w);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_edges.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/atei_pkg.sv
rtl/atei_ram.sv
rtl/adjacency_table_edge_insert.sv
rtl/atei_checker.sv
dv/testbench.sv
